### sv/nsc_pkg.sv
// ----------------------------------------------------------------------------
// nsc_pkg
// Payload types and fixed constants shared by the segment clipper.
// ----------------------------------------------------------------------------
`default_nettype none
package nsc_pkg;

    localparam int CW = 32;
    localparam int CF = 24;
    localparam int TF = 24;
    localparam int TW = TF + 2;

    typedef struct packed {
        logic signed [CW-1:0] start_x;
        logic signed [CW-1:0] start_y;
        logic signed [CW-1:0] start_inv_depth;
        logic                 start_visible;
        logic signed [CW-1:0] end_x;
        logic signed [CW-1:0] end_y;
        logic signed [CW-1:0] end_inv_depth;
        logic                 end_visible;
    } seg_in_t;

    typedef struct packed {
        logic signed [CW-1:0] clip_start_x;
        logic signed [CW-1:0] clip_start_y;
        logic signed [CW-1:0] clip_start_inv_depth;
        logic signed [CW-1:0] clip_end_x;
        logic signed [CW-1:0] clip_end_y;
        logic signed [CW-1:0] clip_end_inv_depth;
        logic                 segment_valid;
        logic                 was_shortened;
    } seg_out_t;

    // Ratio classification: below zero, zero, in range, exactly one, above one.
    typedef enum logic [2:0] {
        R_NEG, R_ZERO, R_DIV, R_ONE, R_OVER
    } rcls_t;

    // Per-item work carried from front to back.
    typedef struct packed {
        logic                 ok;
        logic signed [CW:0]   ax;
        logic signed [CW:0]   ay;
        logic signed [CW:0]   az;
        logic signed [CW+1:0] dx;
        logic signed [CW+1:0] dy;
        logic signed [CW+1:0] dz;
        logic                 xz;
        logic                 yz;
        rcls_t                c0;
        rcls_t                c1;
        rcls_t                c2;
        rcls_t                c3;
        logic [CW+1:0]        n0;
        logic [CW+1:0]        n1;
        logic [CW+1:0]        n2;
        logic [CW+1:0]        n3;
        logic [CW+1:0]        mx;
        logic [CW+1:0]        my;
    } work_t;

endpackage
`default_nettype wire

### sv/nsc_front.sv
// ----------------------------------------------------------------------------
// nsc_front
// Accept a segment, form deltas and boundary numerators, classify ratios.
// ----------------------------------------------------------------------------
`default_nettype none
module nsc_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_stall,
    input  wire nsc_pkg::seg_in_t in_data,
    output logic                w_valid,
    input  wire logic           w_stall,
    output nsc_pkg::work_t      w_data
);
    localparam int W = nsc_pkg::CW + 2;

    logic           w_valid_reg;
    nsc_pkg::work_t w_reg, w_next;

    function automatic nsc_pkg::rcls_t cls(input logic signed [W-1:0] n,
                                           input logic signed [W-1:0] d);
        logic [W-1:0] un, ud;
        un = n[W-1] ? W'(-n) : n;
        ud = d[W-1] ? W'(-d) : d;
        if (n == '0)              return nsc_pkg::R_ZERO;
        else if (n[W-1] != d[W-1]) return nsc_pkg::R_NEG;
        else if (un > ud)         return nsc_pkg::R_OVER;
        else if (un == ud)        return nsc_pkg::R_ONE;
        else                      return nsc_pkg::R_DIV;
    endfunction

    function automatic logic [W-1:0] absv(input logic signed [W-1:0] v);
        return v[W-1] ? W'(-v) : v;
    endfunction

    logic signed [W-1:0] one_c, ax, ay, bx, by, az, bz, dx, dy, n0, n1, n2, n3;

    always_comb
    begin
        one_c = W'(1) <<< nsc_pkg::CF;
        ax = W'(in_data.start_x); ay = W'(in_data.start_y);
        az = W'(in_data.start_inv_depth);
        bx = W'(in_data.end_x);   by = W'(in_data.end_y);
        bz = W'(in_data.end_inv_depth);
        dx = bx - ax; dy = by - ay;
        n0 = -one_c - ax; n1 = one_c - ax;
        n2 = -one_c - ay; n3 = one_c - ay;
        w_next.ok = in_data.start_visible & in_data.end_visible;
        w_next.ax = (nsc_pkg::CW+1)'(ax);
        w_next.ay = (nsc_pkg::CW+1)'(ay);
        w_next.az = (nsc_pkg::CW+1)'(az);
        w_next.dx = dx; w_next.dy = dy; w_next.dz = bz - az;
        w_next.xz = (dx == '0) && !(ax < -one_c || ax > one_c);
        w_next.yz = (dy == '0) && !(ay < -one_c || ay > one_c);
        if (dx == '0) w_next.ok = w_next.ok & w_next.xz;
        if (dy == '0) w_next.ok = w_next.ok & w_next.yz;
        w_next.c0 = cls(n0, dx); w_next.c1 = cls(n1, dx);
        w_next.c2 = cls(n2, dy); w_next.c3 = cls(n3, dy);
        w_next.n0 = absv(n0); w_next.n1 = absv(n1);
        w_next.n2 = absv(n2); w_next.n3 = absv(n3);
        w_next.mx = absv(dx); w_next.my = absv(dy);
    end

    assign in_stall = w_valid_reg && w_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            w_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            w_reg <= w_next;
        end
    end

    assign w_valid = w_valid_reg;
    assign w_data  = w_reg;

endmodule
`default_nettype wire

### sv/nsc_queue.sv
// ----------------------------------------------------------------------------
// nsc_queue
// Two-entry queue that decouples the front from the back.
// ----------------------------------------------------------------------------
`default_nettype none
module nsc_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           i_valid,
    output logic                i_stall,
    input  wire nsc_pkg::work_t i_data,
    output logic                o_valid,
    input  wire logic           o_stall,
    output nsc_pkg::work_t      o_data
);
    nsc_pkg::work_t mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign i_stall = (cnt_reg == 2'd2);
    assign o_valid = (cnt_reg != 2'd0);
    assign push    = i_valid && !i_stall;
    assign pop     = o_valid && !o_stall;
    assign o_data  = mem_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0; rp_reg <= 1'b0; cnt_reg <= 2'd0;
        end
        else
        begin
            if (push) wp_reg <= ~wp_reg;
            if (pop)  rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) mem_reg[wp_reg] <= i_data;
    end

    assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= 2'd2)
        else $error("queue count overflow");
    assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd0) |-> (wp_reg == rp_reg))
        else $error("queue pointers disagree when empty");
    assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd2) |-> (wp_reg == rp_reg))
        else $error("queue pointers disagree when full");

endmodule
`default_nettype wire

### sv/nsc_back.sv
// ----------------------------------------------------------------------------
// nsc_back
// Pipelined divide, entry and exit select, interpolation and output register.
// ----------------------------------------------------------------------------
`default_nettype none
module nsc_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           w_valid,
    output logic                w_stall,
    input  wire nsc_pkg::work_t w_data,
    output logic                out_valid,
    input  wire logic           out_stall,
    output nsc_pkg::seg_out_t   out_data
);
    localparam int CW = nsc_pkg::CW;
    localparam int TF = nsc_pkg::TF;
    localparam int TW = nsc_pkg::TW;
    localparam int DW = CW + 2;
    localparam int NS = TF + 3;
    localparam int NX = 6;

    // ---- stage array: division pipeline, one quotient bit per stage ----
    logic [NS-1:0]  v_reg;
    nsc_pkg::work_t p_reg [NS];
    logic [DW:0]    r_reg [TF+1][4];
    logic [TF-1:0]  q_reg [TF+1][4];
    logic           adv;

    assign adv     = !(out_valid && out_stall);
    assign w_stall = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[NS-2:0], w_valid};
        end
    end

    function automatic logic [DW-1:0] den(input nsc_pkg::work_t p, input int k);
        return (k < 2) ? p.mx : p.my;
    endfunction

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_reg[0] <= w_data;
            r_reg[0][0] <= {1'b0, w_data.n0}; r_reg[0][1] <= {1'b0, w_data.n1};
            r_reg[0][2] <= {1'b0, w_data.n2}; r_reg[0][3] <= {1'b0, w_data.n3};
            for (int k = 0; k < 4; k++) q_reg[0][k] <= '0;
            for (int s = 1; s <= TF; s++)
            begin
                p_reg[s] <= p_reg[s-1];
                for (int k = 0; k < 4; k++)
                begin
                    logic [DW:0] sh;
                    sh = {r_reg[s-1][k][DW-1:0], 1'b0};
                    if (sh >= {1'b0, den(p_reg[s-1], k)})
                    begin
                        r_reg[s][k] <= sh - {1'b0, den(p_reg[s-1], k)};
                        q_reg[s][k] <= {q_reg[s-1][k][TF-2:0], 1'b1};
                    end
                    else
                    begin
                        r_reg[s][k] <= sh;
                        q_reg[s][k] <= {q_reg[s-1][k][TF-2:0], 1'b0};
                    end
                end
            end
            for (int s = TF+1; s < NS; s++)
            begin
                p_reg[s] <= p_reg[s-1];
            end
        end
    end

    // ---- select entry and exit after the divide (stage TF) ----
    function automatic logic signed [TW:0] tval(input nsc_pkg::rcls_t c,
                                               input logic [TF-1:0] q);
        unique case (c)
            nsc_pkg::R_NEG:  return -(TW+1)'(1);
            nsc_pkg::R_ZERO: return '0;
            nsc_pkg::R_DIV:  return (TW+1)'(q);
            nsc_pkg::R_ONE:  return (TW+1)'(1) <<< TF;
            default:         return ((TW+1)'(1) <<< TF) + (TW+1)'(1);
        endcase
    endfunction

    logic signed [TW:0] t0, t1, t2, t3, lo, hi, en, lv;
    logic               keep;
    nsc_pkg::work_t     ps;

    always_comb
    begin
        ps = p_reg[TF];
        t0 = tval(ps.c0, q_reg[TF][0]); t1 = tval(ps.c1, q_reg[TF][1]);
        t2 = tval(ps.c2, q_reg[TF][2]); t3 = tval(ps.c3, q_reg[TF][3]);
        en = '0; lv = (TW+1)'(1) <<< TF; keep = ps.ok;
        if (ps.dx != '0)
        begin
            lo = (t0 < t1) ? t0 : t1; hi = (t0 < t1) ? t1 : t0;
            if (lo > en) en = lo;
            if (hi < lv) lv = hi;
            keep = keep && (en <= lv);
        end
        else
        begin
            lo = t0; hi = t1;
        end
        if (keep && ps.dy != '0)
        begin
            lo = (t2 < t3) ? t2 : t3; hi = (t2 < t3) ? t3 : t2;
            if (lo > en) en = lo;
            if (hi < lv) lv = hi;
            keep = keep && (en <= lv);
        end
    end

    logic               sel_keep_reg;
    logic [TF:0]        en_reg, lv_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sel_keep_reg <= keep;
            en_reg <= en[TF:0];
            lv_reg <= lv[TF:0];
        end
    end

    // ---- multiply at stage TF+1, add at stage TF+2 ----
    logic [DW-1:0] md [NX];
    logic [TF:0]   mt [NX];
    logic [DW+TF:0] prod_reg [NX];
    logic           keep2_reg, short2_reg;

    always_comb
    begin
        md[0] = p_reg[TF+1].dx[DW-1] ? DW'(-p_reg[TF+1].dx) : p_reg[TF+1].dx;
        md[1] = p_reg[TF+1].dy[DW-1] ? DW'(-p_reg[TF+1].dy) : p_reg[TF+1].dy;
        md[2] = p_reg[TF+1].dz[DW-1] ? DW'(-p_reg[TF+1].dz) : p_reg[TF+1].dz;
        md[3] = md[0]; md[4] = md[1]; md[5] = md[2];
        for (int k = 0; k < 3; k++) mt[k] = en_reg;
        for (int k = 3; k < NX; k++) mt[k] = lv_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < NX; k++)
                prod_reg[k] <= (DW+TF+1)'(md[k]) * (DW+TF+1)'(mt[k]);
            keep2_reg  <= sel_keep_reg;
            short2_reg <= (en_reg != '0) || (lv_reg != ((TF+1)'(1) << TF));
        end
    end

    logic signed [CW:0]   base [NX];
    logic                 neg  [NX];
    logic [CW-1:0]        res  [NX];
    nsc_pkg::work_t       pm;
    nsc_pkg::seg_out_t    o_next, o_reg;
    logic                 ov_reg;

    always_comb
    begin
        pm = p_reg[TF+2];
        base[0] = pm.ax; base[1] = pm.ay; base[2] = pm.az;
        base[3] = pm.ax; base[4] = pm.ay; base[5] = pm.az;
        neg[0] = pm.dx[DW-1]; neg[1] = pm.dy[DW-1]; neg[2] = pm.dz[DW-1];
        neg[3] = neg[0]; neg[4] = neg[1]; neg[5] = neg[2];
        for (int k = 0; k < NX; k++)
        begin
            logic [CW:0] m;
            m = prod_reg[k][TF +: CW+1];
            res[k] = neg[k] ? CW'(base[k] - $signed(m)) : CW'(base[k] + $signed(m));
        end
        o_next = '0;
        if (keep2_reg)
        begin
            o_next.clip_start_x = res[0]; o_next.clip_start_y = res[1];
            o_next.clip_start_inv_depth = res[2];
            o_next.clip_end_x = res[3]; o_next.clip_end_y = res[4];
            o_next.clip_end_inv_depth = res[5];
            o_next.segment_valid = 1'b1;
            o_next.was_shortened = short2_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
        end
        else if (adv)
        begin
            ov_reg <= v_reg[NS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv) o_reg <= o_next;
    end

    assign out_valid = ov_reg;
    assign out_data  = o_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> $stable(v_reg))
        else $error("pipeline moved under stall");
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_data.segment_valid) |-> !out_data.was_shortened)
        else $error("shortened flag on rejected segment");
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
        else $error("stalled result beat changed");

endmodule
`default_nettype wire

### sv/ndc_segment_clip.sv
// ----------------------------------------------------------------------------
// ndc_segment_clip
// Parametric clipping of a 2D segment against the unit NDC square.
// ----------------------------------------------------------------------------
// One segment is accepted and one result leaves per cycle while out_stall
// is low. A segment passes the front register, the queue, a 24-stage
// restoring divider that yields one parameter bit per stage for all four
// boundary ratios, the select, multiply and add stages and the output register.
`default_nettype none
module ndc_segment_clip (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire nsc_pkg::seg_in_t    in_data,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output nsc_pkg::seg_out_t        out_data
);
    logic           f_valid, f_stall, q_valid, q_stall;
    nsc_pkg::work_t f_data, q_data;

    nsc_front u_front (
        .clk, .rst_n, .in_valid, .in_stall, .in_data,
        .w_valid(f_valid), .w_stall(f_stall), .w_data(f_data)
    );

    nsc_queue u_queue (
        .clk, .rst_n, .i_valid(f_valid), .i_stall(f_stall), .i_data(f_data),
        .o_valid(q_valid), .o_stall(q_stall), .o_data(q_data)
    );

    nsc_back u_back (
        .clk, .rst_n, .w_valid(q_valid), .w_stall(q_stall), .w_data(q_data),
        .out_valid, .out_stall, .out_data
    );

endmodule
`default_nettype wire
